// File: design/pex5_pkg.sv
// pex5_pkg: shared constants, types and the quad weighting function for the
// 5-tap pyramid expand block. No dependencies.
package pex5_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 1024;
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int ROW_W      = $clog2(MAX_HEIGHT);
  localparam int DIM_W      = 11;
  localparam int PIX_W      = 8;
  localparam int SUM_W      = 15;

  localparam logic [DIM_W-1:0] WIDTH_RESET  = DIM_W'(640);
  localparam logic [DIM_W-1:0] HEIGHT_RESET = DIM_W'(480);
  localparam logic [DIM_W-1:0] WIDTH_MAX    = DIM_W'(MAX_WIDTH);
  localparam logic [DIM_W-1:0] HEIGHT_MAX   = DIM_W'(MAX_HEIGHT);

  typedef enum logic [0:0] {
    REG_WIDTH  = 1'b0,
    REG_HEIGHT = 1'b1
  } reg_idx_t;

  typedef logic [PIX_W-1:0] pix_t;
  typedef pix_t [2:0][2:0] win_t;   // [row][col], row 2 / col 2 newest

  typedef struct packed {
    logic [SUM_W-1:0] ee;
    logic [SUM_W-1:0] eo;
    logic [SUM_W-1:0] oe;
    logic [SUM_W-1:0] oo;
  } quad_t;

  // Weights in tenths: even 1,8,1 over -1,0,+1; odd 5,5 over 0,+1.
  function automatic quad_t quad_sum(input win_t n);
    logic [11:0] ce [3];
    logic [11:0] co [3];
    logic [8:0]  ps;
    logic [12:0] te;
    logic [12:0] to;
    quad_t       q;
    for (int a = 0; a < 3; a++) begin
      ps    = {1'b0, n[a][1]} + {1'b0, n[a][2]};
      ce[a] = {4'b0, n[a][0]} + {1'b0, n[a][1], 3'b0} + {4'b0, n[a][2]};
      co[a] = {1'b0, ps, 2'b0} + {3'b0, ps};
    end
    q.ee = {3'b0, ce[0]} + {ce[1], 3'b0} + {3'b0, ce[2]};
    q.eo = {3'b0, co[0]} + {co[1], 3'b0} + {3'b0, co[2]};
    te   = {1'b0, ce[1]} + {1'b0, ce[2]};
    to   = {1'b0, co[1]} + {1'b0, co[2]};
    q.oe = SUM_W'({te, 2'b0}) + SUM_W'(te);
    q.oo = SUM_W'({to, 2'b0}) + SUM_W'(to);
    return q;
  endfunction

endpackage

// File: design/pyramid_expand_5tap.sv
// pyramid_expand_5tap: 2x Gaussian pyramid expand, 5-tap kernel, raster input.
// Depends on pex5_pkg (constants, window/quad types, quad_sum).
//
//  channel | signals                                   | dir | notes
//  --------+-------------------------------------------+-----+-------------------------
//  pixel   | pixel_valid, pixel_stall, pixel           | in  | one source pixel
//  quad    | quad_valid, quad_stall, 4 sums, row, col, | out | 2x2 output quad, x100
//          | last_quad                                 |     |
//  config  | cfg_write, cfg_index, cfg_data            | in  | width / height, no wait
//
// One pixel per clock in steady state, unless a pixel with quads waits in stage 1 for a
// burst in progress or the output, stalling the input. A pixel's first quad passes the
// line RAM read, the burst register and the quad output register; quads leave one per
// cycle while quad_stall is low. Line memory is one 1024 x 16 RAM holding the two rows
// above; a same-column read during its write (width of one) is served from a forwarding
// register. rst is synchronous; a config write restarts the frame at row 0, column 0.
module pyramid_expand_5tap (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          pixel_valid,
  output logic                          pixel_stall,
  input  logic [pex5_pkg::PIX_W-1:0]    pixel,
  output logic                          quad_valid,
  input  logic                          quad_stall,
  output logic [pex5_pkg::SUM_W-1:0]    even_row_even_col,
  output logic [pex5_pkg::SUM_W-1:0]    even_row_odd_col,
  output logic [pex5_pkg::SUM_W-1:0]    odd_row_even_col,
  output logic [pex5_pkg::SUM_W-1:0]    odd_row_odd_col,
  output logic [pex5_pkg::ROW_W-1:0]    quad_row,
  output logic [pex5_pkg::COL_W-1:0]    quad_col,
  output logic                          last_quad,
  input  logic                          cfg_write,
  input  logic                          cfg_index,
  input  logic [pex5_pkg::DIM_W-1:0]    cfg_data
);
  import pex5_pkg::*;

  // configuration
  logic [DIM_W-1:0] image_width;
  logic [DIM_W-1:0] image_height;
  logic [DIM_W-1:0] w_eff;
  logic [DIM_W-1:0] h_eff;

  // frame position of the next pixel
  logic [ROW_W-1:0] row_count;
  logic [COL_W-1:0] col_count;

  // line RAM: {row r-2, row r-1} per column
  logic [2*PIX_W-1:0] line_mem [MAX_WIDTH];
  logic [2*PIX_W-1:0] rd_data;
  logic [2*PIX_W-1:0] fwd_word;
  logic               fwd_valid;

  // stage 1
  logic             s1_valid;
  pix_t             s1_pix;
  logic [ROW_W-1:0] s1_row;
  logic [COL_W-1:0] s1_col;
  logic             s1_clr;
  logic             s1_r1;
  logic             s1_r2;
  logic [3:0]       s1_mask;
  logic             s1_go;

  win_t             window;
  win_t             window_next;
  logic [2*PIX_W-1:0] word;
  logic [2*PIX_W-1:0] wr_word;

  // quad burst
  logic [3:0]       b_mask;
  win_t             b_win;
  logic [ROW_W-1:0] b_row;
  logic [COL_W-1:0] b_col;
  logic             b_valid;
  logic             b_done;
  logic             b_load;
  logic             burst_ready;
  logic [3:0]       sel;
  logic [1:0]       cen_r;
  logic [1:0]       cen_c;
  logic [ROW_W-1:0] sel_row;
  logic [COL_W-1:0] sel_col;
  logic             sel_last;
  win_t             nbhd;
  quad_t            q;

  logic             accept;
  logic             o_free;
  logic             emit;
  logic             endc;
  logic             endr;
  logic [3:0]       mask0;

  // ---------------- stage 0: accept, RAM read ----------------
  always_comb begin
    priority if (image_width == '0)       w_eff = DIM_W'(1);
    else if (image_width > WIDTH_MAX)     w_eff = WIDTH_MAX;
    else                                  w_eff = image_width;
    priority if (image_height == '0)      h_eff = DIM_W'(1);
    else if (image_height > HEIGHT_MAX)   h_eff = HEIGHT_MAX;
    else                                  h_eff = image_height;
    endc     = ({1'b0, col_count} >= w_eff - DIM_W'(1));
    endr     = ({1'b0, row_count} >= h_eff - DIM_W'(1));
    mask0[0] = (row_count != '0) && (col_count != '0);
    mask0[1] = (row_count != '0) && endc;
    mask0[2] = endr && (col_count != '0);
    mask0[3] = endr && endc;
  end

  assign pixel_stall = s1_valid && !s1_go;
  assign accept      = pixel_valid && !pixel_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= WIDTH_RESET;
      image_height <= HEIGHT_RESET;
      row_count    <= '0;
      col_count    <= '0;
    end else if (cfg_write) begin
      unique case (reg_idx_t'(cfg_index))
        REG_WIDTH:  image_width  <= cfg_data;
        REG_HEIGHT: image_height <= cfg_data;
        default:    ;
      endcase
      row_count <= '0;
      col_count <= '0;
    end else if (accept) begin
      if (endc) begin
        col_count <= '0;
        row_count <= endr ? '0 : row_count + ROW_W'(1);
      end else begin
        col_count <= col_count + COL_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go) line_mem[s1_col] <= wr_word;
    if (accept) rd_data <= line_mem[col_count];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fwd_valid <= 1'b0;
    end else if (accept) begin
      fwd_valid <= s1_go && (s1_col == col_count);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) fwd_word <= wr_word;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_go) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_pix  <= pixel;
      s1_row  <= row_count;
      s1_col  <= col_count;
      s1_clr  <= (col_count == '0);
      s1_r1   <= (row_count != '0);
      s1_r2   <= (row_count > ROW_W'(1));
      s1_mask <= mask0;
    end
  end

  // ---------------- stage 1: window shift, RAM write-back ----------------
  always_comb begin
    word    = fwd_valid ? fwd_word : rd_data;
    wr_word = {word[PIX_W-1:0], s1_pix};
    for (int k = 0; k < 3; k++) begin
      window_next[k][0] = s1_clr ? '0 : window[k][1];
      window_next[k][1] = s1_clr ? '0 : window[k][2];
    end
    window_next[0][2] = s1_r2 ? word[2*PIX_W-1:PIX_W] : '0;
    window_next[1][2] = s1_r1 ? word[PIX_W-1:0] : '0;
    window_next[2][2] = s1_pix;
  end

  assign s1_go = s1_valid && ((s1_mask == '0) || burst_ready);

  always_ff @(posedge clk) begin
    if (rst || cfg_write) begin
      window <= '0;
    end else if (s1_go) begin
      window <= window_next;
    end
  end

  // ---------------- quad burst: one quad per cycle ----------------
  // a pixel with no quads passes by without touching a burst in progress
  assign b_load      = s1_go && (s1_mask != '0);
  assign b_valid     = (b_mask != '0);
  assign o_free      = !quad_valid || !quad_stall;
  assign emit        = b_valid && o_free;
  assign b_done      = ((b_mask & ~sel) == '0);
  assign burst_ready = !b_valid || (o_free && b_done);

  always_comb begin
    sel      = '0;
    cen_r    = 2'd1;
    cen_c    = 2'd1;
    sel_row  = b_row - ROW_W'(1);
    sel_col  = b_col - COL_W'(1);
    sel_last = 1'b0;
    priority if (b_mask[0]) begin
      sel = 4'b0001;
    end else if (b_mask[1]) begin
      sel     = 4'b0010;
      cen_c   = 2'd2;
      sel_col = b_col;
    end else if (b_mask[2]) begin
      sel     = 4'b0100;
      cen_r   = 2'd2;
      sel_row = b_row;
    end else if (b_mask[3]) begin
      sel      = 4'b1000;
      cen_r    = 2'd2;
      cen_c    = 2'd2;
      sel_row  = b_row;
      sel_col  = b_col;
      sel_last = 1'b1;
    end else begin
      sel = '0;
    end
  end

  // 3x3 neighborhood around the quad's center; off-window samples are zero
  always_comb begin
    logic [2:0] ri;
    logic [2:0] ci;
    for (int a = 0; a < 3; a++) begin
      for (int b = 0; b < 3; b++) begin
        ri = {1'b0, cen_r} + 3'(a) - 3'd1;
        ci = {1'b0, cen_c} + 3'(b) - 3'd1;
        nbhd[a][b] = (ri > 3'd2 || ci > 3'd2) ? '0 : b_win[ri[1:0]][ci[1:0]];
      end
    end
    q = quad_sum(nbhd);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b_mask <= '0;
    end else if (b_load) begin
      b_mask <= s1_mask;
    end else if (emit) begin
      b_mask <= b_mask & ~sel;
    end
  end

  always_ff @(posedge clk) begin
    if (b_load) begin
      b_win <= window_next;
      b_row <= s1_row;
      b_col <= s1_col;
    end
  end

  // ---------------- output register ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      quad_valid <= 1'b0;
    end else if (o_free) begin
      quad_valid <= b_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      even_row_even_col <= q.ee;
      even_row_odd_col  <= q.eo;
      odd_row_even_col  <= q.oe;
      odd_row_odd_col   <= q.oo;
      quad_row          <= sel_row;
      quad_col          <= sel_col;
      last_quad         <= sel_last;
    end
  end

endmodule
